@@ src/spq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int PRIO_W   = 3;
    localparam int ID_W     = 30;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } t_entry;

    // per-cell control, one copy built for each slot
    typedef struct packed {
        logic ins;   // insert accepted this cycle
        logic rem;   // remove accepted this cycle
        logic used;  // slot holds a live entry
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ src/spq_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if;
    import spq_pkg::*;
    logic              valid;
    logic              ready;
    logic              func;
    logic [PRIO_W-1:0] priority_req;
    logic [ID_W-1:0]   patient_id;

    modport source (output valid, func, priority_req, patient_id, input ready);
    modport sink   (input valid, func, priority_req, patient_id, output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                out_valid;
    logic [PRIO_W-1:0]   out_priority;
    logic [ID_W-1:0]     out_id;
    logic                now_empty;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, status, out_valid, out_priority, out_id, now_empty,
                    occupancy, input ready);
    modport sink   (input valid, status, out_valid, out_priority, out_id, now_empty,
                    occupancy, output ready);
endinterface

`default_nettype wire

@@ src/spq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic      i_clk,
    input  t_cell_ctl      i_ctl,
    input  t_entry         i_new,
    input  wire logic      i_prev_stay,
    input  t_entry         i_prev,
    input  t_entry         i_next,
    output t_entry         o_entry,
    output logic           o_stay
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_stay;

    // keep slot on insert when it holds an equal or more urgent entry
    assign w_stay  = i_ctl.used && (r_entry.prio <= i_new.prio);
    assign o_stay  = w_stay;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.ins) begin
            if (w_stay) begin
                n_entry = r_entry;
            end else if (i_prev_stay) begin
                n_entry = i_new;
            end else begin
                n_entry = i_prev;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_next;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

@@ src/stable_priority_queue_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Stable priority queue of up to QUEUE_DEPTH entries, kept sorted in a row of
// cells with slot 0 as the head; a lower level is more urgent and entries of
// one level leave in arrival order. Each accepted item (insert or remove)
// yields one result item in the following cycle, and a new item is taken
// every cycle as long as the result register is free or being drained, so
// the sustained rate is one item per cycle while o_out.ready holds. All cells
// shift or hold in the same cycle, so no item waits on the one before it.
// Remove on an empty queue returns status 1, insert on a full queue returns
// status 2 and drops the entry; occupancy is reported modulo 32.
module stable_priority_queue_top
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spq_in_if.sink     i_in,
    spq_out_if.source  o_out
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic             w_ins;
    logic             w_rem;
    t_entry           w_new;
    t_entry           w_entry [QUEUE_DEPTH];
    logic             w_stay  [QUEUE_DEPTH];

    logic                r_res_valid;
    t_status             r_status;
    logic                r_out_valid;
    logic [PRIO_W-1:0]   r_out_priority;
    logic [ID_W-1:0]     r_out_id;
    logic                r_now_empty;
    logic [OCC_W-1:0]    r_occupancy;
    t_status             n_status;
    logic [CNT_W+OCC_W-1:0] w_occ_ext;

    assign i_in.ready = !r_res_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_ins      = w_accept && (t_func'(i_in.func) == FUNC_INSERT) && !w_full;
    assign w_rem      = w_accept && (t_func'(i_in.func) == FUNC_REMOVE) && !w_empty;
    assign w_new      = '{prio: i_in.priority_req, id: i_in.patient_id};

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            t_cell_ctl w_ctl;
            logic      w_prev_stay;
            t_entry    w_prev;
            t_entry    w_next;

            assign w_ctl.ins  = w_ins;
            assign w_ctl.rem  = w_rem;
            assign w_ctl.used = (CNT_W'(g) < r_count);

            if (g == 0) begin : g_head
                assign w_prev_stay = 1'b1;
                assign w_prev      = w_new;
            end else begin : g_body
                assign w_prev_stay = w_stay[g-1];
                assign w_prev      = w_entry[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_next = w_entry[g];
            end else begin : g_mid
                assign w_next = w_entry[g+1];
            end

            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_new       (w_new),
                .i_prev_stay (w_prev_stay),
                .i_prev      (w_prev),
                .i_next      (w_next),
                .o_entry     (w_entry[g]),
                .o_stay      (w_stay[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + 1'b1;
        end else if (w_rem) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_status = ST_OK;
        unique case (t_func'(i_in.func))
            FUNC_INSERT: if (w_full) n_status = ST_FULL;
            FUNC_REMOVE: if (w_empty) n_status = ST_EMPTY;
            default:     n_status = ST_OK;
        endcase
    end

    assign w_occ_ext = {{OCC_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_res_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // hold the result payload until the next item is accepted
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status       <= n_status;
            r_out_valid    <= w_rem;
            r_out_priority <= w_rem ? w_entry[0].prio : '0;
            r_out_id       <= w_rem ? w_entry[0].id : '0;
            r_now_empty    <= (n_count == '0);
            r_occupancy    <= w_occ_ext[OCC_W-1:0];
        end
    end

    assign o_out.valid        = r_res_valid;
    assign o_out.status       = r_status;
    assign o_out.out_valid    = r_out_valid;
    assign o_out.out_priority = r_out_priority;
    assign o_out.out_id       = r_out_id;
    assign o_out.now_empty    = r_now_empty;
    assign o_out.occupancy    = r_occupancy;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && (t_func'(i_in.func) == FUNC_INSERT)) |=>
            (r_count == $past(r_count)) && (r_status == ST_FULL))
        else $error("refused insert changed the count");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_entry[0].prio <= w_entry[1].prio))
        else $error("head entries out of order");

    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_out_valid) |-> (r_status == ST_OK))
        else $error("removed entry with error status");

endmodule

`default_nettype wire
